// File: rtl/ssra_pkg.sv
// Shared constants for the swap slot reference-count allocator.
package ssra_pkg;

  // Table geometry
  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORDS     = SLOTS / WORD_BITS;
  localparam int WORD_W    = $clog2(WORDS);

  // Field widths
  localparam int CNT_W    = 8;
  localparam int SLOTF_W  = 11;
  localparam int SECT_W   = 13;
  localparam int SPS_SHIFT = 3;  // eight sectors per slot

  // Action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_DROP  = 2'd2;

endpackage

// File: rtl/swap_slot_refcount_allocator.sv
// Swap slot allocator with per-slot 8-bit reference counts.
// Channels: requests enter on s_* (tdata: action[1:0], slot[12:2]); results
// leave on m_* (tdata: ok[0], slot_number[11:1], first_sector[24:12],
// count_after[32:25]). cfg_* writes the count ceiling at any time the block
// is idle; cfg_ready is always high.
// A request that updates a count runs these steps from acceptance to a loaded
// result: accept, look up the free-word summary and read the memories, update
// the count through one shared +1/-1 unit, load the output register. A request
// refused at lookup (slot out of range, unused action, table full) skips the
// update step. s_tready is high only while the sequencer is idle, so a new
// request is taken only after the last one's result has been loaded.
// Free slots are tracked in a 32 x 32-bit bitmap memory plus a 32-bit
// summary of words holding a free slot; allocation finds the first word from
// the summary and the first bit from the word read.
// Reset clears the sequencer, the output valid, the summary (all free) and
// the per-word valid bits; a word never written reads as all free and its
// counts read as zero, so no clearing pass runs and requests are taken in
// the first cycle after reset.
// A stalled receiver holds the result in the output register; one more
// request can be accepted and processed meanwhile and waits for the register.
module swap_slot_refcount_allocator
  import ssra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // action[1:0], slot[12:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // ok[0], slot_number[11:1], first_sector[24:12],
                                 // count_after[32:25], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // count ceiling
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_READ, S_DONE} state_t;

  state_t                   state;
  logic [1:0]               act_q;
  logic [SLOTF_W-1:0]       slot_q;
  logic [WORD_W-1:0]        word_q;
  logic [BIT_W-1:0]         bit_q;
  logic [CNT_W-1:0]         max_q;
  logic [WORDS-1:0]         hasfree;
  logic [WORDS-1:0]         wvalid;

  // Result held between the lookup or update step and the output register
  logic                     res_ok;
  logic [SLOTF_W-1:0]       res_slot;
  logic [SECT_W-1:0]        res_sect;
  logic [CNT_W-1:0]         res_cnt;

  // Memories and their registered read data
  logic [CNT_W-1:0]         refcnt [SLOTS];
  logic [WORD_BITS-1:0]     bitmap [WORDS];
  logic [CNT_W-1:0]         cnt_q;
  logic [WORD_BITS-1:0]     bm_q;

  // Lookup-step signals
  logic [SLOT_W-1:0]        look_idx;
  logic [WORD_W-1:0]        look_word;
  logic                     look_fail;

  // Update-step signals
  logic [WORD_BITS-1:0]     bm_cur;
  logic [BIT_W-1:0]         alloc_bit;
  logic [BIT_W-1:0]         bit_sel;
  logic [SLOT_W-1:0]        upd_idx;
  logic [CNT_W-1:0]         cnt_cur;
  logic [CNT_W-1:0]         cnt_new;
  logic                     refuse;
  logic [WORD_BITS-1:0]     bm_new;
  logic                     wr_en;

  function automatic logic [WORD_W-1:0] first_word(input logic [WORDS-1:0] v);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WORD_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Decode the request: slot range check, word of the slot or first free word
  always_comb begin
    look_idx  = SLOT_W'(slot_q - SLOTF_W'(1));
    look_word = look_idx[SLOT_W-1:BIT_W];
    look_fail = 1'b0;
    case (act_q)
      ACT_ALLOC: begin
        look_word = first_word(hasfree);
        look_fail = (hasfree == '0);
      end
      ACT_ADD, ACT_DROP: begin
        look_fail = (slot_q == '0) || (32'(slot_q) > 32'(SLOTS));
      end
      default: look_fail = 1'b1;
    endcase
  end

  // Update the count through one shared increment/decrement unit
  always_comb begin
    bm_cur    = wvalid[word_q] ? bm_q : '1;
    alloc_bit = first_bit(bm_cur);
    bit_sel   = (act_q == ACT_ALLOC) ? alloc_bit : bit_q;
    upd_idx   = {word_q, bit_sel};
    cnt_cur   = bm_cur[bit_sel] ? '0 : cnt_q;
    cnt_new   = (act_q == ACT_DROP) ? cnt_cur - CNT_W'(1) : cnt_cur + CNT_W'(1);
    case (act_q)
      ACT_ADD:  refuse = (cnt_cur >= max_q);
      ACT_DROP: refuse = (cnt_cur == '0);
      default:  refuse = 1'b0;
    endcase
    bm_new          = bm_cur;
    bm_new[bit_sel] = (cnt_new == '0);
    wr_en           = (state == S_READ) && !refuse;
  end

  // Read the memories during lookup, write them during update
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      cnt_q <= refcnt[look_idx];
      bm_q  <= bitmap[look_word];
    end
    if (wr_en) begin
      refcnt[upd_idx] <= cnt_new;
      bitmap[word_q]  <= bm_new;
    end
  end

  // Sequencer, summary bits, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      max_q    <= CNT_W'(255);
      hasfree  <= '1;
      wvalid   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) max_q <= cfg_data;
      // Drop a taken result unless the next one loads in the same cycle
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act_q  <= s_tdata[1:0];
            slot_q <= s_tdata[12:2];
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          word_q <= look_word;
          bit_q  <= look_idx[BIT_W-1:0];
          if (look_fail) begin
            res_ok   <= 1'b0;
            res_slot <= '0;
            res_sect <= '0;
            res_cnt  <= '0;
            state    <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (wr_en) begin
            wvalid[word_q]  <= 1'b1;
            hasfree[word_q] <= |bm_new;
          end
          res_ok   <= !refuse;
          res_slot <= SLOTF_W'(32'(upd_idx) + 32'd1);
          res_sect <= refuse ? '0 : SECT_W'({upd_idx, {SPS_SHIFT{1'b0}}});
          res_cnt  <= refuse ? cnt_cur : cnt_new;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, res_cnt, res_sect, res_slot, res_ok};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result appears only when the sequencer finishes a request
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result valid without a finished request");

  // A successful result never names slot zero
  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[11:1] != '0))
    else $error("successful result with slot zero");

  // A refused result carries no sector
  a_fail_sect: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[24:12] == '0))
    else $error("refused result with nonzero sector");

  // Memory writes happen only in the update step
  a_write_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == S_DONE))
    else $error("memory write outside the update step");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the swap slot reference-count allocator.
`timescale 1ns / 100ps

module tb_top;
  import ssra_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;   // unused action code
  localparam int SECTORS_PER_SLOT = 8;
  localparam int LIMIT_CYCLES     = 200000;
  localparam int MAX_SHOWN        = 30;

  typedef struct packed {
    logic [SLOTF_W-1:0] slot;
    logic [1:0]         action;
  } swap_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count_after;
    logic [SECT_W-1:0]  first_sector;
    logic [SLOTF_W-1:0] slot_number;
    logic               ok;
  } swap_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;     // action[1:0], slot[12:2], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // ok[0], slot_number[11:1], first_sector[24:12],
                                 // count_after[32:25], zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;    // count ceiling

  // Predicted table state and register copy
  logic [CNT_W-1:0] slot_cnt [1:SLOTS];
  logic [CNT_W-1:0] cnt_ceiling;

  swap_req_t req_backlog[$];
  swap_res_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int alloc_hint    = 0;
  int errors        = 0;
  int reqs_sent     = 0;
  int results_seen  = 0;
  int refusals      = 0;
  int full_hits     = 0;
  int ceiling_hits  = 0;
  int cycles        = 0;

  swap_slot_refcount_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one request to the predicted table and return the expected result
  function automatic swap_res_t slot_table_step(swap_req_t rq);
    swap_res_t r;
    int        idx;
    bit        found;
    r     = '0;
    found = 1'b0;
    case (rq.action)
      ACT_ALLOC: begin
        for (idx = 1; idx <= SLOTS && !found; idx++) begin
          if (slot_cnt[idx] == 0) begin
            found          = 1'b1;
            slot_cnt[idx]  = 1;
            r.ok           = 1'b1;
            r.slot_number  = SLOTF_W'(idx);
            r.first_sector = SECT_W'((idx - 1) * SECTORS_PER_SLOT);
            r.count_after  = 1;
          end
        end
        if (!found) full_hits++;
      end
      ACT_ADD, ACT_DROP: begin
        if (rq.slot != 0 && rq.slot <= SLOTS) begin
          r.slot_number = rq.slot;
          if (rq.action == ACT_ADD && slot_cnt[rq.slot] >= cnt_ceiling) begin
            ceiling_hits++;
          end else if (rq.action == ACT_DROP && slot_cnt[rq.slot] == 0) begin
            // drop at zero stays at zero
          end else begin
            if (rq.action == ACT_ADD) slot_cnt[rq.slot] = slot_cnt[rq.slot] + 1;
            else slot_cnt[rq.slot] = slot_cnt[rq.slot] - 1;
            r.ok           = 1'b1;
            r.first_sector = SECT_W'((rq.slot - 1) * SECTORS_PER_SLOT);
          end
          r.count_after = slot_cnt[rq.slot];
        end
      end
      default: ;
    endcase
    if (!r.ok) refusals++;
    return r;
  endfunction

  // Request driver: predict on acceptance, then load the next request
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(slot_table_step(swap_req_t'(s_tdata[12:0])));
        reqs_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= {3'b000, req_backlog.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    swap_res_t want;
    swap_res_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = swap_res_t'(m_tdata[32:0]);
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("slot_number", want.slot_number, got.slot_number);
          check_field("first_sector", want.first_sector, got.first_sector);
          check_field("count_after", want.count_after, got.count_after);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] act, int unsigned slot);
    swap_req_t rq;
    rq.action = act;
    rq.slot   = SLOTF_W'(slot);
    req_backlog.push_back(rq);
    if (act == ACT_ALLOC) alloc_hint++;
  endtask

  // Hold until every queued request has been answered
  task automatic drain_all();
    do @(negedge clk);
    while (req_backlog.size() != 0 || s_tvalid || pending_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_ceiling(logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cnt_ceiling = value;
    cfg_valid <= 1'b0;
  endtask

  // Mostly live slots, some noise: out of range slots and the unused action
  task automatic queue_random(int n);
    int r;
    int hi;
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(99);
      hi = (alloc_hint + 2 > SLOTS) ? SLOTS : alloc_hint + 2;
      if (r < 45)      push_req(ACT_ALLOC, $urandom_range(2047));
      else if (r < 70) push_req(ACT_ADD, $urandom_range(hi, 1));
      else if (r < 90) push_req(ACT_DROP, $urandom_range(hi, 1));
      else if (r < 95) push_req($urandom_range(1) ? ACT_ADD : ACT_DROP,
                                $urandom_range(1) ? 0 : $urandom_range(2047, SLOTS + 1));
      else             push_req(ACT_NONE, $urandom_range(2047));
    end
  endtask

  initial begin
    int n_free;
    int hot_slot;
    for (int s = 1; s <= SLOTS; s++) slot_cnt[s] = '0;
    cnt_ceiling = 8'd255;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: first fit, reuse, range edges, unused action, drop at zero
    send_idle_pct = 31;
    recv_idle_pct = 83;
    write_ceiling(8'd255);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_ALLOC, 2047);
    push_req(ACT_ADD, 1);
    push_req(ACT_DROP, 2);
    push_req(ACT_DROP, 2);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_ADD, 0);
    push_req(ACT_DROP, 0);
    push_req(ACT_ADD, SLOTS + 1);
    push_req(ACT_DROP, 2047);
    push_req(ACT_NONE, 2047);
    push_req(ACT_NONE, 1);
    push_req(ACT_ADD, SLOTS);
    push_req(ACT_DROP, SLOTS);
    push_req(ACT_DROP, SLOTS);
    drain_all();

    // Count at the ceiling, then a ceiling of zero
    write_ceiling(8'd1);
    push_req(ACT_ADD, 1);
    push_req(ACT_ADD, 3);
    push_req(ACT_ADD, 3);
    drain_all();
    write_ceiling(8'd0);
    push_req(ACT_ADD, 4);
    push_req(ACT_DROP, 1);
    drain_all();

    // Low ceiling, sender idles less than receiver; pause midway
    write_ceiling(8'($urandom_range(6, 2)));
    queue_random(50);
    drain_all();
    queue_random(50);
    drain_all();

    // Full ceiling: drive one slot up to 255 and past it
    send_idle_pct = 83;
    recv_idle_pct = 31;
    write_ceiling(8'd255);
    hot_slot = $urandom_range(16, 1);
    for (int k = 0; k < 258; k++) push_req(ACT_ADD, hot_slot);
    queue_random(80);
    drain_all();

    // No idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_ceiling(8'd128);
    queue_random(100);
    drain_all();

    // Fill the table, punch holes, refill and hit full again
    write_ceiling(8'($urandom_range(255, 1)));
    n_free = 0;
    for (int s = 1; s <= SLOTS; s++) if (slot_cnt[s] == 0) n_free++;
    for (int k = 0; k < n_free + 3; k++) push_req(ACT_ALLOC, $urandom_range(2047));
    for (int k = 0; k < 6; k++) push_req(ACT_DROP, $urandom_range(SLOTS, 1));
    for (int k = 0; k < 8; k++) push_req(ACT_ALLOC, $urandom_range(2047));
    drain_all();

    $display("tb_top: %0d requests answered by %0d results, %0d refused", reqs_sent,
             results_seen, refusals);
    $display("tb_top: table full %0d times, add refused at ceiling %0d times",
             full_hits, ceiling_hits);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ssra_pkg.sv
rtl/swap_slot_refcount_allocator.sv
tb/tb_top.sv
